[hw/rtl/ffa_pkg.sv]
// Shared types, constants and helpers for the first-fit free-list allocator.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
package ffa_pkg;

	localparam int FREE_SLOTS   = 256;
	localparam int QUANTUM      = 16;
	localparam int MIN_BLOCK    = 16;
	localparam int START_OFFSET = 64;
	localparam int OFFSET_BITS  = 32;

	localparam int SLOT_W = $clog2(FREE_SLOTS);
	localparam int CNT_W  = $clog2(FREE_SLOTS + 1);
	localparam int THR_W  = 9;

	typedef logic [OFFSET_BITS-1:0] off_t;

	// One table entry: offset in the upper half, size in the lower half.
	typedef struct packed {
		off_t off;
		off_t size;
	} slot_t;

	typedef enum logic [1:0] {
		KIND_ALLOC    = 2'd0,
		KIND_FREE     = 2'd1,
		KIND_COALESCE = 2'd2,
		KIND_NONE     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_DROPPED   = 2'd2,
		ST_NULL_FREE = 2'd3
	} status_t;

	typedef enum logic {
		REG_THRESHOLD = 1'b0,
		REG_LIMIT     = 1'b1
	} reg_idx_t;

	// Round a byte count up to the quantum, with a floor of the minimum block.
	// The result may be one bit wider than an offset.
	function automatic logic [OFFSET_BITS:0] round_size(input off_t s);
		logic [OFFSET_BITS:0] t;
		t = {1'b0, s} + (OFFSET_BITS+1)'(QUANTUM - 1);
		t = (t / QUANTUM) * QUANTUM;
		if (t < (OFFSET_BITS+1)'(MIN_BLOCK)) begin
			t = (OFFSET_BITS+1)'(MIN_BLOCK);
		end
		return t;
	endfunction

endpackage

[hw/rtl/ffa_if.sv]
// Valid/ready channel interfaces for requests and results of the allocator.
// Depends on ffa_pkg for the field types.
`timescale 1ns / 1ps
interface ffa_req_if import ffa_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	off_t       block_offset;
	off_t       req_size;

	modport source (output valid, kind, block_offset, req_size, input ready);
	modport sink (input valid, kind, block_offset, req_size, output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; ();
	logic             valid;
	logic             ready;
	off_t             grant_offset;
	logic [1:0]       status;
	logic [CNT_W-1:0] free_entries;
	off_t             free_total;
	off_t             top_offset;

	modport source (output valid, grant_offset, status, free_entries, free_total,
		top_offset, input ready);
	modport sink (input valid, grant_offset, status, free_entries, free_total,
		top_offset, output ready);
endinterface

[hw/rtl/first_fit_free_list_allocator.sv]
// Top level of the first-fit free-list allocator: control FSM and slot memory.
// Depends on ffa_pkg and the channel interfaces in ffa_if.sv.
//
// Usage: a request (kind, block_offset, req_size) is taken on req when valid and
// ready are high; exactly one result is offered on rsp for each request.
// Configuration (coalesce threshold, arena limit) is written through cfg_we,
// cfg_index and cfg_wdata while no request is in flight.
// The free table lives in one synchronous memory in reversed order: the head of
// the list is the highest occupied slot, so a free is a single write.
// Steps per request, all set by the single read and write port of that memory:
//   free: a push at the head (dropped when the table is full), then a threshold
//     check that may start a coalesce; null free and unused kind go straight on.
//   allocate: a scan of entries from the head, then the bump pointer when no
//     entry fits (at once on an empty table), plus a move of each entry nearer
//     the head when a whole entry is taken out below the head.
//   coalesce: a reversal pass (two reads and two writes per pair), an insertion
//     sort, a merge pass and a second reversal pass.
// The result sits in an output register; a new request is taken while it waits.
// If the receiver stalls, a finished request holds in its last state until the
// output register frees up. Reset empties the table, clears the byte count and
// sets the bump pointer to its start offset; the memory itself is not cleared.
`timescale 1ns / 1ps
module first_fit_free_list_allocator import ffa_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  off_t          cfg_wdata,
	ffa_req_if.sink       req,
	ffa_rsp_if.source     rsp
);

	typedef enum logic [19:0] {
		S_IDLE   = 20'h00001,
		S_AST    = 20'h00002,
		S_SRCH   = 20'h00004,
		S_RM     = 20'h00008,
		S_BUMP   = 20'h00010,
		S_FREE   = 20'h00020,
		S_FCHK   = 20'h00040,
		S_RVA    = 20'h00080,
		S_RVB    = 20'h00100,
		S_RVC    = 20'h00200,
		S_RVD    = 20'h00400,
		S_SKEY   = 20'h00800,
		S_SKEYW  = 20'h01000,
		S_SCMP   = 20'h02000,
		S_SPUT   = 20'h04000,
		S_MSTART = 20'h08000,
		S_MFIRST = 20'h10000,
		S_MCMP   = 20'h20000,
		S_MEND   = 20'h40000,
		S_DONE   = 20'h80000
	} state_t;

	localparam logic [OFFSET_BITS:0] OFF_MAX = {1'b0, {OFFSET_BITS{1'b1}}};

	state_t               state_q, state_d;
	logic [1:0]           kind_q, kind_d;
	logic [OFFSET_BITS:0] n_q, n_d;
	off_t                 boff_q, boff_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	off_t                 bytes_q, bytes_d;
	off_t                 bump_q, bump_d;
	logic [THR_W-1:0]     thr_q;
	off_t                 limit_q;
	logic [CNT_W-1:0]     ia_q, ia_d;
	logic [CNT_W-1:0]     ib_q, ib_d;
	slot_t                key_q, key_d;
	off_t                 grant_q, grant_d;
	status_t              status_q, status_d;
	logic                 rev2_q, rev2_d;

	// Slot memory ports.
	slot_t                mem [FREE_SLOTS];
	logic                 mem_we, mem_re;
	logic [SLOT_W-1:0]    mem_waddr, mem_raddr;
	slot_t                mem_wdata;
	slot_t                rd_data_q;

	// Result register.
	logic                 rsp_valid_q;
	off_t                 rsp_grant_q;
	status_t              rsp_status_q;
	logic [CNT_W-1:0]     rsp_entries_q;
	off_t                 rsp_total_q;
	off_t                 rsp_top_q;
	logic                 rsp_load;

	// Datapath helpers.
	logic [OFFSET_BITS:0]   rnd;
	off_t                   rem;
	logic [OFFSET_BITS+1:0] bump_end;
	logic [OFFSET_BITS:0]   cur_end, merged;

	assign rnd      = round_size(req.req_size);
	assign rem      = rd_data_q.size - n_q[OFFSET_BITS-1:0];
	assign bump_end = {2'b0, bump_q} + {1'b0, n_q};
	assign cur_end  = {1'b0, key_q.off} + {1'b0, key_q.size};
	assign merged   = {1'b0, key_q.size} + {1'b0, rd_data_q.size};

	assign req.ready = (state_q == S_IDLE);
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	// Next-state and memory port logic.
	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		n_d       = n_q;
		boff_d    = boff_q;
		cnt_d     = cnt_q;
		bytes_d   = bytes_q;
		bump_d    = bump_q;
		ia_d      = ia_q;
		ib_d      = ib_q;
		key_d     = key_q;
		grant_d   = grant_q;
		status_d  = status_q;
		rev2_d    = rev2_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = rd_data_q;
		mem_re    = 1'b0;
		mem_raddr = '0;

		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					kind_d   = req.kind;
					n_d      = rnd;
					boff_d   = req.block_offset;
					grant_d  = '0;
					status_d = ST_OK;
					case (req.kind)
						KIND_ALLOC: state_d = (cnt_q == '0) ? S_BUMP : S_AST;
						KIND_FREE: state_d = S_FREE;
						KIND_COALESCE: begin
							rev2_d  = 1'b0;
							ia_d    = '0;
							ib_d    = (cnt_q == '0) ? '0 : cnt_q - 1'b1;
							state_d = S_RVA;
						end
						default: state_d = S_DONE;
					endcase
				end
			end

			// Start the scan at the head of the list.
			S_AST: begin
				mem_re    = 1'b1;
				mem_raddr = SLOT_W'(cnt_q - 1'b1);
				ia_d      = cnt_q - 1'b1;
				state_d   = S_SRCH;
			end

			// First fit: one entry per cycle from the head downward.
			S_SRCH: begin
				if ({1'b0, rd_data_q.size} >= n_q) begin
					grant_d = rd_data_q.off;
					if (rem >= OFFSET_BITS'(MIN_BLOCK)) begin
						mem_we         = 1'b1;
						mem_waddr      = SLOT_W'(ia_q);
						mem_wdata.off  = rd_data_q.off + n_q[OFFSET_BITS-1:0];
						mem_wdata.size = rem;
						bytes_d        = bytes_q - n_q[OFFSET_BITS-1:0];
						state_d        = S_DONE;
					end else begin
						bytes_d = bytes_q - rd_data_q.size;
						if (ia_q + 1'b1 < cnt_q) begin
							mem_re    = 1'b1;
							mem_raddr = SLOT_W'(ia_q + 1'b1);
							ia_d      = ia_q + 1'b1;
							state_d   = S_RM;
						end else begin
							cnt_d   = cnt_q - 1'b1;
							state_d = S_DONE;
						end
					end
				end else if (ia_q == '0) begin
					state_d = S_BUMP;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = SLOT_W'(ia_q - 1'b1);
					ia_d      = ia_q - 1'b1;
				end
			end

			// Close the gap: entries nearer the head move down one slot.
			S_RM: begin
				mem_we    = 1'b1;
				mem_waddr = SLOT_W'(ia_q - 1'b1);
				mem_wdata = rd_data_q;
				if (ia_q + 1'b1 < cnt_q) begin
					mem_re    = 1'b1;
					mem_raddr = SLOT_W'(ia_q + 1'b1);
					ia_d      = ia_q + 1'b1;
				end else begin
					cnt_d   = cnt_q - 1'b1;
					state_d = S_DONE;
				end
			end

			S_BUMP: begin
				if (bump_end <= {2'b0, limit_q} && bump_end <= {1'b0, OFF_MAX}) begin
					grant_d = bump_q;
					bump_d  = bump_end[OFFSET_BITS-1:0];
				end else begin
					status_d = ST_EXHAUSTED;
				end
				state_d = S_DONE;
			end

			// Push at the head, which is the next free slot.
			S_FREE: begin
				if (boff_q == '0) begin
					status_d = ST_NULL_FREE;
					state_d  = S_DONE;
				end else begin
					if (cnt_q >= CNT_W'(FREE_SLOTS)) begin
						status_d = ST_DROPPED;
					end else begin
						mem_we         = 1'b1;
						mem_waddr      = SLOT_W'(cnt_q);
						mem_wdata.off  = boff_q;
						mem_wdata.size = n_q[OFFSET_BITS] ? OFF_MAX[OFFSET_BITS-1:0]
							: n_q[OFFSET_BITS-1:0];
						cnt_d          = cnt_q + 1'b1;
						bytes_d        = bytes_q + mem_wdata.size;
					end
					state_d = S_FCHK;
				end
			end

			S_FCHK: begin
				if (thr_q != '0 && cnt_q > CNT_W'(thr_q)) begin
					rev2_d  = 1'b0;
					ia_d    = '0;
					ib_d    = (cnt_q == '0) ? '0 : cnt_q - 1'b1;
					state_d = S_RVA;
				end else begin
					state_d = S_DONE;
				end
			end

			// Reversal pass: swap the pair at ia and ib.
			S_RVA: begin
				if (ia_q < ib_q) begin
					mem_re    = 1'b1;
					mem_raddr = SLOT_W'(ia_q);
					state_d   = S_RVB;
				end else if (rev2_q) begin
					state_d = S_DONE;
				end else if (cnt_q >= CNT_W'(2)) begin
					ia_d    = CNT_W'(1);
					state_d = S_SKEY;
				end else begin
					state_d = S_MSTART;
				end
			end

			S_RVB: begin
				mem_re    = 1'b1;
				mem_raddr = SLOT_W'(ib_q);
				key_d     = rd_data_q;
				state_d   = S_RVC;
			end

			S_RVC: begin
				mem_we    = 1'b1;
				mem_waddr = SLOT_W'(ia_q);
				mem_wdata = rd_data_q;
				state_d   = S_RVD;
			end

			S_RVD: begin
				mem_we    = 1'b1;
				mem_waddr = SLOT_W'(ib_q);
				mem_wdata = key_q;
				ia_d      = ia_q + 1'b1;
				ib_d      = ib_q - 1'b1;
				state_d   = S_RVA;
			end

			// Stable insertion sort by offset, list order now matches slot order.
			S_SKEY: begin
				mem_re    = 1'b1;
				mem_raddr = SLOT_W'(ia_q);
				state_d   = S_SKEYW;
			end

			S_SKEYW: begin
				key_d     = rd_data_q;
				ib_d      = ia_q;
				mem_re    = 1'b1;
				mem_raddr = SLOT_W'(ia_q - 1'b1);
				state_d   = S_SCMP;
			end

			S_SCMP: begin
				mem_we    = 1'b1;
				mem_waddr = SLOT_W'(ib_q);
				if (rd_data_q.off > key_q.off) begin
					mem_wdata = rd_data_q;
					ib_d      = ib_q - 1'b1;
					if (ib_q > CNT_W'(1)) begin
						mem_re    = 1'b1;
						mem_raddr = SLOT_W'(ib_q - 2'd2);
					end else begin
						state_d = S_SPUT;
					end
				end else begin
					mem_wdata = key_q;
					if (ia_q + 1'b1 < cnt_q) begin
						ia_d    = ia_q + 1'b1;
						state_d = S_SKEY;
					end else begin
						state_d = S_MSTART;
					end
				end
			end

			S_SPUT: begin
				mem_we    = 1'b1;
				mem_waddr = SLOT_W'(ib_q);
				mem_wdata = key_q;
				if (ia_q + 1'b1 < cnt_q) begin
					ia_d    = ia_q + 1'b1;
					state_d = S_SKEY;
				end else begin
					state_d = S_MSTART;
				end
			end

			// Merge pass: the running block sits in key, ib is the write slot.
			S_MSTART: begin
				if (cnt_q == '0) begin
					state_d = S_DONE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = '0;
					state_d   = S_MFIRST;
				end
			end

			S_MFIRST: begin
				key_d = rd_data_q;
				ib_d  = '0;
				if (cnt_q > CNT_W'(1)) begin
					mem_re    = 1'b1;
					mem_raddr = SLOT_W'(1);
					ia_d      = CNT_W'(1);
					state_d   = S_MCMP;
				end else begin
					state_d = S_MEND;
				end
			end

			S_MCMP: begin
				if (cur_end == {1'b0, rd_data_q.off}) begin
					key_d.size = (merged > OFF_MAX) ? OFF_MAX[OFFSET_BITS-1:0]
						: merged[OFFSET_BITS-1:0];
				end else begin
					mem_we    = 1'b1;
					mem_waddr = SLOT_W'(ib_q);
					mem_wdata = key_q;
					ib_d      = ib_q + 1'b1;
					key_d     = rd_data_q;
				end
				if (ia_q + 1'b1 < cnt_q) begin
					mem_re    = 1'b1;
					mem_raddr = SLOT_W'(ia_q + 1'b1);
					ia_d      = ia_q + 1'b1;
				end else begin
					state_d = S_MEND;
				end
			end

			// Last block out, then reverse back into head-at-top order.
			S_MEND: begin
				mem_we    = 1'b1;
				mem_waddr = SLOT_W'(ib_q);
				mem_wdata = key_q;
				cnt_d     = ib_q + 1'b1;
				rev2_d    = 1'b1;
				ia_d      = '0;
				state_d   = S_RVA;
			end

			S_DONE: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			bytes_q  <= '0;
			bump_q   <= OFFSET_BITS'(START_OFFSET);
			thr_q    <= '0;
			limit_q  <= '1;
			rev2_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			bytes_q <= bytes_d;
			bump_q  <= bump_d;
			rev2_q  <= rev2_d;
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_THRESHOLD: thr_q   <= cfg_wdata[THR_W-1:0];
					REG_LIMIT:     limit_q <= cfg_wdata;
					default:       thr_q   <= thr_q;
				endcase
			end
		end
	end

	// Working registers of the current request.
	always_ff @(posedge clk) begin
		kind_q   <= kind_d;
		n_q      <= n_d;
		boff_q   <= boff_d;
		ia_q     <= ia_d;
		ib_q     <= ib_d;
		key_q    <= key_d;
		grant_q  <= grant_d;
		status_q <= status_d;
	end

	// Slot memory, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	// Output register; a transfer on rsp frees it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_grant_q   <= grant_q;
			rsp_status_q  <= status_q;
			rsp_entries_q <= cnt_q;
			rsp_total_q   <= bytes_q;
			rsp_top_q     <= bump_q;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.grant_offset = (kind_q == KIND_ALLOC || rsp_grant_q != '0) ? rsp_grant_q : '0;
	assign rsp.status       = rsp_status_q;
	assign rsp.free_entries = rsp_entries_q;
	assign rsp.free_total   = rsp_total_q;
	assign rsp.top_offset   = rsp_top_q;

	// The table never holds more entries than it has slots.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FREE_SLOTS))
		else $error("free entry count beyond table size");

	// The memory is only written while a request is being worked on.
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !mem_we)
		else $error("slot write while idle");

	// A new result appears only out of the finishing state.
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result loaded outside finishing state");

	// The bump pointer only moves upward.
	a_bump_mono: assert property (@(posedge clk) disable iff (!arst_n)
		bump_q >= $past(bump_q))
		else $error("bump pointer moved down");

endmodule

[verif/first_fit_free_list_allocator_checker.sv]
// Checker for the first-fit free-list allocator: watches the request, result and
// configuration ports, predicts every result and compares it. Depends on ffa_pkg and ffa_if.sv.
`timescale 1ns / 1ps
module first_fit_free_list_allocator_checker import ffa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_we,
	input  logic  cfg_index,
	input  off_t  cfg_wdata,
	ffa_req_if    req,
	ffa_rsp_if    rsp,
	output int    mismatches,
	output int    pending
);

	localparam longint unsigned OFF_MAX = (64'd1 << OFFSET_BITS) - 1;

	typedef struct {
		off_t             grant;
		status_t          st;
		logic [CNT_W-1:0] entries;
		off_t             total;
		off_t             top;
	} heap_result_t;

	heap_result_t expected_q[$];

	// Predicted free table, head at index 0, plus counters and registers.
	longint unsigned tbl_off[FREE_SLOTS];
	longint unsigned tbl_size[FREE_SLOTS];
	int unsigned     n_entries;
	longint unsigned bytes_free;
	longint unsigned bump;
	int unsigned     threshold;
	longint unsigned limit;

	function automatic longint unsigned quantize(input longint unsigned s);
		longint unsigned n;
		n = ((s + QUANTUM - 1) / QUANTUM) * QUANTUM;
		if (n < MIN_BLOCK) begin
			n = MIN_BLOCK;
		end
		return n;
	endfunction

	// Stable sort by offset, then merge blocks that touch.
	task automatic merge_table();
		int unsigned     i, j, w;
		longint unsigned o, s, t;
		for (i = 1; i < n_entries; i++) begin
			o = tbl_off[i];
			s = tbl_size[i];
			j = i;
			while (j > 0 && tbl_off[j-1] > o) begin
				tbl_off[j]  = tbl_off[j-1];
				tbl_size[j] = tbl_size[j-1];
				j--;
			end
			tbl_off[j]  = o;
			tbl_size[j] = s;
		end
		if (n_entries != 0) begin
			w = 0;
			for (i = 1; i < n_entries; i++) begin
				if (tbl_off[w] + tbl_size[w] == tbl_off[i]) begin
					t = tbl_size[w] + tbl_size[i];
					tbl_size[w] = (t > OFF_MAX) ? OFF_MAX : t;
				end else begin
					w++;
					tbl_off[w]  = tbl_off[i];
					tbl_size[w] = tbl_size[i];
				end
			end
			n_entries = w + 1;
		end
	endtask

	task automatic predict_heap(input kind_t k, input off_t boff, input off_t sz);
		heap_result_t    r;
		longint unsigned n, rem, top_end;
		bit              found;
		int unsigned     i;
		r.grant = '0;
		r.st    = ST_OK;
		found   = 1'b0;
		case (k)
			KIND_ALLOC: begin
				n = quantize(sz);
				for (i = 0; i < n_entries && !found; i++) begin
					if (tbl_size[i] >= n) begin
						rem     = tbl_size[i] - n;
						r.grant = off_t'(tbl_off[i]);
						found   = 1'b1;
						if (rem >= MIN_BLOCK) begin
							tbl_off[i]  = (tbl_off[i] + n) & OFF_MAX;
							tbl_size[i] = rem;
							bytes_free  = (bytes_free - n) & OFF_MAX;
						end else begin
							// The whole entry goes out; close the gap behind it.
							bytes_free = (bytes_free - tbl_size[i]) & OFF_MAX;
							for (int unsigned m = i; m + 1 < n_entries; m++) begin
								tbl_off[m]  = tbl_off[m+1];
								tbl_size[m] = tbl_size[m+1];
							end
							n_entries--;
						end
					end
				end
				if (!found) begin
					top_end = bump + n;
					if (n <= OFF_MAX && top_end <= limit && top_end <= OFF_MAX) begin
						r.grant = off_t'(bump);
						bump    = top_end;
					end else begin
						r.st = ST_EXHAUSTED;
					end
				end
			end
			KIND_FREE: begin
				if (boff == '0) begin
					r.st = ST_NULL_FREE;
				end else begin
					n = quantize(sz);
					if (n > OFF_MAX) begin
						n = OFF_MAX;
					end
					if (n_entries >= FREE_SLOTS) begin
						r.st = ST_DROPPED;
					end else begin
						for (i = n_entries; i > 0; i--) begin
							tbl_off[i]  = tbl_off[i-1];
							tbl_size[i] = tbl_size[i-1];
						end
						tbl_off[0]  = boff;
						tbl_size[0] = n;
						n_entries++;
						bytes_free = (bytes_free + n) & OFF_MAX;
					end
					if (threshold != 0 && n_entries > threshold) begin
						merge_table();
					end
				end
			end
			KIND_COALESCE: merge_table();
			default: ;
		endcase
		r.entries = n_entries[CNT_W-1:0];
		r.total   = off_t'(bytes_free);
		r.top     = off_t'(bump);
		expected_q.push_back(r);
	endtask

	task automatic report_mismatch(input string field, input longint unsigned got,
		input longint unsigned want);
		$display("%0t: %s mismatch, got %0h, expected %0h", $realtime, field, got, want);
		mismatches++;
	endtask

	// Predict on each request transfer, compare on each result transfer.
	always @(posedge clk or negedge arst_n) begin
		heap_result_t e;
		if (!arst_n) begin
			expected_q.delete();
			n_entries  = 0;
			bytes_free = 0;
			bump       = START_OFFSET;
			threshold  = 0;
			limit      = 64'hFFFF_FFFF;
			mismatches = 0;
			pending    = 0;
		end else begin
			if (cfg_we) begin
				if (reg_idx_t'(cfg_index) == REG_THRESHOLD) begin
					threshold = cfg_wdata[THR_W-1:0];
				end else begin
					limit = cfg_wdata;
				end
			end
			if (req.valid && req.ready) begin
				predict_heap(kind_t'(req.kind), req.block_offset, req.req_size);
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					// A result transfer with nothing expected.
					report_mismatch("unexpected result", 64'd1, 64'd0);
				end else begin
					e = expected_q.pop_front();
					if (rsp.grant_offset !== e.grant) begin
						report_mismatch("grant_offset", rsp.grant_offset, e.grant);
					end
					if (rsp.status !== e.st) begin
						report_mismatch("status", rsp.status, e.st);
					end
					if (rsp.free_entries !== e.entries) begin
						report_mismatch("free_entries", rsp.free_entries, e.entries);
					end
					if (rsp.free_total !== e.total) begin
						report_mismatch("free_total", rsp.free_total, e.total);
					end
					if (rsp.top_offset !== e.top) begin
						report_mismatch("top_offset", rsp.top_offset, e.top);
					end
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

[verif/first_fit_free_list_allocator_test.sv]
// Testbench top for the first-fit free-list allocator: clock, reset, stimulus and verdict.
// Depends on ffa_pkg, ffa_if.sv, the allocator RTL and the checker module.
`timescale 1ns / 1ps
module first_fit_free_list_allocator_test;
	import ffa_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	off_t cfg_wdata;
	int   mismatches;
	int   pending;
	bit   quiet;
	int   stall_left;

	ffa_req_if req ();
	ffa_rsp_if rsp ();

	first_fit_free_list_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	first_fit_free_list_allocator_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.req        (req),
		.rsp        (rsp),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Result side: ready drops in random bursts, except in the quiet phase.
	always @(posedge clk) begin
		if (quiet) begin
			rsp.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp.ready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 19) - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// One request transfer, with an optional idle burst in front of it.
	task automatic send_req(input kind_t k, input off_t boff, input off_t sz);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req.valid        <= 1'b1;
		req.kind         <= k;
		req.block_offset <= boff;
		req.req_size     <= sz;
		do @(posedge clk); while (!req.ready);
	endtask

	// Stop sending and wait for every outstanding result.
	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input off_t value);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Random requests; frees are mostly aligned near the heap start so that blocks merge.
	task automatic random_req();
		int   r;
		off_t sz;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			r = $urandom_range(0, 99);
			sz = (r < 80) ? $urandom_range(0, 256) :
				(r < 90) ? $urandom : $urandom_range(0, 4096);
			send_req(KIND_ALLOC, $urandom, sz);
		end else if (r < 80) begin
			sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 100) :
				16 * $urandom_range(1, 8);
			send_req(KIND_FREE, 64 + 16 * $urandom_range(0, 4095), sz);
		end else if (r < 85) begin
			send_req(KIND_FREE, $urandom, $urandom);
		end else if (r < 89) begin
			send_req(KIND_FREE, '0, $urandom);
		end else if (r < 93) begin
			send_req(KIND_NONE, $urandom, $urandom);
		end else begin
			send_req(KIND_COALESCE, $urandom, $urandom);
		end
	endtask

	// Watchdog: full-table coalescing on every item would still finish well inside this.
	initial begin
		repeat (200_000_000) @(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		quiet            = 1'b0;
		stall_left       = 0;
		cfg_we           = 1'b0;
		cfg_index        = REG_THRESHOLD;
		cfg_wdata        = '0;
		req.valid        = 1'b0;
		req.kind         = KIND_ALLOC;
		req.block_offset = '0;
		req.req_size     = '0;
		rsp.ready        = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bump limit hit exactly, then one past it.
		write_reg(REG_LIMIT, 32'd80);
		send_req(KIND_ALLOC, '0, '0);
		send_req(KIND_ALLOC, '0, 32'd1);
		write_reg(REG_LIMIT, '1);
		send_req(KIND_NONE, '1, '1);
		send_req(KIND_FREE, '0, 32'd5);
		send_req(KIND_COALESCE, '0, '0);
		// Exact fit takes the whole entry.
		send_req(KIND_FREE, 32'd64, 32'd16);
		send_req(KIND_ALLOC, '0, 32'd16);
		// Split near the top of the range wraps the entry offset to zero.
		send_req(KIND_FREE, 32'hFFFF_FFF0, 32'd64);
		send_req(KIND_ALLOC, '0, 32'd16);
		send_req(KIND_ALLOC, '0, 32'd48);
		// Huge free sizes saturate, and the byte count wraps.
		send_req(KIND_FREE, 32'h1000, '1);
		send_req(KIND_FREE, 32'h2000, 32'hFFFF_FFF1);
		send_req(KIND_ALLOC, '0, '1);
		send_req(KIND_ALLOC, '0, 32'hFFFF_FFF0);
		send_req(KIND_ALLOC, '0, 32'hFFFF_FFF0);
		// Merged size saturates; a duplicate offset stays apart.
		send_req(KIND_FREE, 32'h10, 32'h8000_0000);
		send_req(KIND_FREE, 32'h8000_0010, 32'h8000_0000);
		send_req(KIND_FREE, 32'h10, 32'd32);
		send_req(KIND_COALESCE, '0, '0);
		send_req(KIND_ALLOC, '0, 32'hFFFF_FFF0);
		send_req(KIND_ALLOC, '0, 32'd32);
		send_req(KIND_ALLOC, '0, 32'hFFFF_FFF0);

		// Fill the table to the brim; the next free is dropped.
		for (int i = 0; i <= FREE_SLOTS; i++) begin
			send_req(KIND_FREE, 32'h1000_0000 + 16 * i, 32'd16);
		end
		// A dropped free on a full table still triggers coalescing.
		write_reg(REG_THRESHOLD, 9'd255);
		send_req(KIND_FREE, 32'h2000_0000, 32'd16);

		write_reg(REG_THRESHOLD, '0);
		repeat (170) random_req();
		write_reg(REG_THRESHOLD, 9'd1);
		write_reg(REG_LIMIT, '0);
		repeat (150) random_req();
		write_reg(REG_THRESHOLD, 9'd256);
		write_reg(REG_LIMIT, 32'h0004_0000);
		repeat (150) random_req();
		write_reg(REG_THRESHOLD, 9'd8);
		write_reg(REG_LIMIT, '1);
		repeat (150) random_req();
		write_reg(REG_THRESHOLD, 9'd3);
		quiet = 1'b1;
		repeat (150) random_req();
		drain();

		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
